>>> rtl/core/bmp_pixel_to_rgb565_macros.svh
// Assertion macros used by the bitmap pixel converter top level.
`ifndef BMP_PIXEL_TO_RGB565_MACROS_SVH
`define BMP_PIXEL_TO_RGB565_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define BP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bp2rgb_pkg.sv
// Types, constants and helper functions of the bitmap pixel converter.
package bp2rgb_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int WIDTH_BITS  = 12;
   localparam int POS_BITS    = 14;
   localparam int PIXEL_BITS  = 16;

   typedef enum logic [1:0] {
      FMT_RGB555  = 2'd0,
      FMT_RGB565  = 2'd1,
      FMT_BGR24   = 2'd2,
      FMT_BGRX32  = 2'd3
   } fmt_type;

   typedef enum logic {
      REG_PIXEL_FORMAT = 1'b0,
      REG_IMAGE_WIDTH  = 1'b1
   } reg_index_type;

   // Live configuration plus the row geometry derived from it.
   typedef struct packed {
      fmt_type               fmt;
      logic [POS_BITS-1:0]   visible;
      logic [POS_BITS-1:0]   stride;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [PIXEL_BITS-1:0] pixel;
      logic                  row_end;
   } result_type;

   // Clamp width into 1..MAX_WIDTH.
   function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] r;
      r = w;
      if (w == '0) r = WIDTH_BITS'(1);
      else if (w > WIDTH_BITS'(MAX_WIDTH)) r = WIDTH_BITS'(MAX_WIDTH);
      return r;
   endfunction

   // Visible bytes of one row.
   function automatic logic [POS_BITS-1:0] calc_visible(input fmt_type fmt,
                                                        input logic [WIDTH_BITS-1:0] w);
      logic [POS_BITS-1:0] wx;
      logic [POS_BITS-1:0] r;
      wx = POS_BITS'(w);
      case (fmt)
         FMT_BGRX32: r = wx << 2;
         FMT_BGR24:  r = (wx << 1) + wx;
         default:    r = wx << 1;
      endcase
      return r;
   endfunction

   // Row stride: visible bytes rounded up to a 4-byte multiple.
   function automatic logic [POS_BITS-1:0] calc_stride(input logic [POS_BITS-1:0] v);
      logic [POS_BITS:0] s;
      s = ({1'b0, v} + (POS_BITS+1)'(3)) & ~((POS_BITS+1)'(3));
      return s[POS_BITS-1:0];
   endfunction

   function automatic logic [PIXEL_BITS-1:0] pack565(input logic [7:0] b,
                                                     input logic [7:0] g,
                                                     input logic [7:0] r);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

>>> rtl/core/bmp_pixel_to_rgb565.sv
// Top level of the BMP pixel-array to RGB565 stream converter.
// Usage:
//  - req_ carries the BMP pixel array one byte per transfer in file order;
//    req_tuser marks the first byte of an image and restarts the row counters.
//  - rsp_ gives one RGB565 pixel per complete source pixel; rsp_tlast flags the
//    last visible pixel of a row. Row padding bytes give no transfer.
//  - csr_ writes pixel_format (index 0) and image_width (index 1); always ready.
//    Write only while the block is idle. Row geometry is worked out at the write.
// Timing:
//  - One byte per cycle while req_tready is high. A pixel is registered in the output
//    register, or in the skid entry while the output register is held by a stall.
//  - A two-entry output buffer (register plus skid) lets input keep flowing while
//    one result waits; req_tready drops only when both entries are full.
// Reset: counters cleared, format RGB565, width 320, output buffer emptied.
// Stall: rsp_tdata/rsp_tlast hold while rsp_tvalid is high and rsp_tready low.
module bmp_pixel_to_rgb565
   import bp2rgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input byte stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] frame_start
   // pixel stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_BITS-1:0] rsp_tdata,   // [15:0] pixel
   output logic                  rsp_tlast,   // row_end
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [WIDTH_BITS-1:0] csr_wdata
);

`include "bmp_pixel_to_rgb565_macros.svh"

   cfg_type                  cfg_ff, cfg_in;
   logic [WIDTH_BITS-1:0]    width_ff, width_in;
   fmt_type                  new_fmt;
   logic [WIDTH_BITS-1:0]    new_width;

   logic                     req_accept;
   result_type               res;

   logic                     rsp_vld_ff, rsp_vld_in;
   logic [PIXEL_BITS-1:0]    rsp_px_ff,  rsp_px_in;
   logic                     rsp_end_ff, rsp_end_in;
   logic                     skid_vld_ff, skid_vld_in;
   logic [PIXEL_BITS-1:0]    skid_px_ff,  skid_px_in;
   logic                     skid_end_ff, skid_end_in;
   logic                     pop;

   logic                     push_stalled;
   logic                     stride_ok;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      new_fmt   = cfg_ff.fmt;
      new_width = width_ff;
      case (reg_index_type'(csr_index))
         REG_PIXEL_FORMAT: new_fmt   = fmt_type'(csr_wdata[1:0]);
         REG_IMAGE_WIDTH:  new_width = eff_width(csr_wdata);
         default:          ;
      endcase
      cfg_in   = cfg_ff;
      width_in = width_ff;
      if (csr_valid) begin
         width_in       = new_width;
         cfg_in.fmt     = new_fmt;
         cfg_in.visible = calc_visible(new_fmt, new_width);
         cfg_in.stride  = calc_stride(calc_visible(new_fmt, new_width));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WIDTH_BITS'(320);
         cfg_ff.fmt     <= FMT_RGB565;
         cfg_ff.visible <= POS_BITS'(640);
         cfg_ff.stride  <= POS_BITS'(640);
      end else begin
         width_ff <= width_in;
         cfg_ff   <= cfg_in;
      end
   end

   // ---------------- byte unpacking ----------------
   assign req_tready = !skid_vld_ff;
   assign req_accept = req_tvalid && req_tready;

   bp2rgb_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .take        (req_accept),
      .data_byte   (req_tdata),
      .frame_start (req_tuser),
      .cfg         (cfg_ff),
      .result      (res)
   );

   // ---------------- output register plus skid ----------------
   assign pop = rsp_vld_ff && rsp_tready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_px_in   = rsp_px_ff;
      rsp_end_in  = rsp_end_ff;
      skid_vld_in = skid_vld_ff;
      skid_px_in  = skid_px_ff;
      skid_end_in = skid_end_ff;
      if (skid_vld_ff) begin
         // input is blocked here; drain skid into the main register
         if (pop) begin
            rsp_px_in   = skid_px_ff;
            rsp_end_in  = skid_end_ff;
            skid_vld_in = 1'b0;
         end
      end else if (req_accept && res.valid) begin
         if (!rsp_vld_ff || pop) begin
            rsp_vld_in = 1'b1;
            rsp_px_in  = res.pixel;
            rsp_end_in = res.row_end;
         end else begin
            skid_vld_in = 1'b1;
            skid_px_in  = res.pixel;
            skid_end_in = res.row_end;
         end
      end else if (pop) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      rsp_px_ff   <= rsp_px_in;
      rsp_end_ff  <= rsp_end_in;
      skid_px_ff  <= skid_px_in;
      skid_end_ff <= skid_end_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_px_ff;
   assign rsp_tlast  = rsp_end_ff;

   // ---------------- assertions ----------------
   assign push_stalled = req_accept && res.valid && rsp_vld_ff && !rsp_tready;
   assign stride_ok    = (cfg_ff.stride >= cfg_ff.visible) && (cfg_ff.stride[1:0] == 2'b00);

   `BP_ASSERT_IMPL(a_skid_behind_main, skid_vld_ff, rsp_vld_ff, "skid full with main empty")
   `BP_ASSERT_NEXT(a_stalled_push_kept, push_stalled, skid_vld_ff, "result lost on stall")
   `BP_ASSERT_IMPL(a_stride_covers_row, 1'b1, stride_ok, "bad row stride")
   `BP_ASSERT_NEXT(a_skid_drains, skid_vld_ff && rsp_tready, !skid_vld_ff, "skid not drained")

endmodule

>>> rtl/core/bp2rgb_unpack.sv
// Row/pixel byte counters and the byte-to-RGB565 conversion.
module bp2rgb_unpack
   import bp2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        frame_start,
   input  cfg_type     cfg,
   output result_type  result
);

   logic [POS_BITS-1:0]   pos_ff,  pos_in;
   logic [1:0]            k_ff,    k_in;
   logic [PIXEL_BITS-1:0] held_ff, held_in;

   logic [POS_BITS-1:0]   pos_cur;
   logic [1:0]            k_cur;
   logic [PIXEL_BITS-1:0] held_cur;
   logic [POS_BITS:0]     pos_next;
   logic [1:0]            last_idx;
   logic [PIXEL_BITS-1:0] word;
   logic [PIXEL_BITS-1:0] px;

   always_comb begin
      pos_cur  = frame_start ? '0 : pos_ff;
      k_cur    = frame_start ? '0 : k_ff;
      held_cur = frame_start ? '0 : held_ff;

      case (cfg.fmt)
         FMT_BGRX32: last_idx = 2'd3;
         FMT_BGR24:  last_idx = 2'd2;
         default:    last_idx = 2'd1;
      endcase

      word = {data_byte, held_cur[7:0]};
      case (cfg.fmt)
         FMT_RGB555: px = {word[14:10], word[9:5], 1'b0, word[4:0]};
         FMT_RGB565: px = word;
         FMT_BGR24:  px = pack565(held_cur[7:0], held_cur[15:8], data_byte);
         default:    px = held_cur;
      endcase

      pos_in          = pos_ff;
      k_in            = k_ff;
      held_in         = held_ff;
      result.valid    = 1'b0;
      result.pixel    = px;
      pos_next        = {1'b0, pos_cur} + (POS_BITS+1)'(1);
      result.row_end  = (pos_next == {1'b0, cfg.visible});

      if (take) begin
         k_in    = k_cur;
         held_in = held_cur;
         if (pos_cur < cfg.visible) begin
            if (k_cur < last_idx) begin
               case (k_cur)
                  2'd0:    held_in = {8'h00, data_byte};
                  2'd1:    held_in = word;
                  default: held_in = pack565(held_cur[7:0], held_cur[15:8], data_byte);
               endcase
               k_in = k_cur + 2'd1;
            end else begin
               result.valid = 1'b1;
               k_in         = '0;
            end
         end
         // wrap at the padded stride
         if (pos_next >= {1'b0, cfg.stride}) begin
            pos_in = '0;
            k_in   = '0;
         end else begin
            pos_in = pos_next[POS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         k_ff    <= '0;
         held_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         k_ff    <= k_in;
         held_ff <= held_in;
      end
   end

endmodule

>>> tb/bmp_pixel_to_rgb565_test.sv
// Stream testbench for the BMP pixel-array to RGB565 converter.
`timescale 1ns / 100ps

module bmp_pixel_to_rgb565_test;
   import bp2rgb_pkg::*;

   localparam int  RANDOM_BYTES = 1000;  // random bytes to send before stopping
   localparam int  CALM_BYTES   = 880;   // after this many, no more idling
   localparam int  HOLD_CYCLES  = 64;    // long receiver hold-off
   localparam int  SETTLE       = 4;     // cycles after the last result
   localparam real LIMIT_NS     = 5.0e6;

   // Directed table: byte transfers and register writes in one list.
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_FORMAT,
      ROW_WIDTH
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [WIDTH_BITS-1:0] value;     // byte, format or width
      logic                  frame;     // frame_start on this byte
      logic                  typed;     // a pixel is typed in below
      logic [15:0]           pixel;
      logic                  row_end;
   } stim_row_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  row_end;
   } rgb_out_type;

   localparam int N_DIRECTED = 28;

   // Extremes of each format, row padding and width clamping at both ends.
   stim_row_type directed_rows [0:N_DIRECTED-1] = '{
      // straight after reset: RGB565, 320 wide
      '{ROW_BYTE,   12'h034, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h012, 1'b0, 1'b1, 16'h1234, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      // RGB555, one pixel per row: 2 visible bytes, 2 padding
      '{ROW_FORMAT, 12'(FMT_RGB555), 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WIDTH,  12'd1,   1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h07F, 1'b0, 1'b1, 16'hFFDF, 1'b1},
      '{ROW_BYTE,   12'h0AA, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h055, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h080, 1'b0, 1'b1, 16'h0000, 1'b1},
      // BGR 24-bit, width 0 clamps to 1: 3 visible, 1 padding
      '{ROW_FORMAT, 12'(FMT_BGR24), 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WIDTH,  12'd0,   1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b0, 1'b1, 16'hFFFF, 1'b1},
      '{ROW_BYTE,   12'h011, 1'b0, 1'b0, 16'h0000, 1'b0},
      // BGRX 32-bit, width 4095 clamps to the maximum
      '{ROW_FORMAT, 12'(FMT_BGRX32), 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WIDTH,  12'hFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h000, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h077, 1'b0, 1'b1, 16'hF800, 1'b0},
      '{ROW_BYTE,   12'h0FF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BYTE,   12'h000, 1'b0, 1'b1, 16'h001F, 1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  req_tuser;   // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIXEL_BITS-1:0] rsp_tdata;   // [15:0] pixel
   logic                  rsp_tlast;   // row_end
   logic                  csr_valid;
   logic                  csr_ready;
   reg_index_type         csr_index;
   logic [WIDTH_BITS-1:0] csr_wdata;

   bmp_pixel_to_rgb565 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow of the converter: registers and row counters as they stand after
   // every accepted byte.
   fmt_type               cur_fmt   = FMT_RGB565;
   logic [WIDTH_BITS-1:0] cur_width = 12'd320;
   logic [POS_BITS-1:0]   row_pos   = '0;
   logic [1:0]            pix_byte  = '0;
   logic [15:0]           held      = '0;

   rgb_out_type pending_pixels [$];   // converted pixels not yet seen on rsp_

   int  errors         = 0;
   int  bytes_sent     = 0;
   int  pixels_checked = 0;
   int  row_ends_seen  = 0;
   int  reg_writes     = 0;
   bit  tx_idle_on     = 1'b0;
   bit  rx_idle_on     = 1'b0;
   bit  hold_output    = 1'b0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL bmp_pixel_to_rgb565");
      $finish;
   end

   // Visible bytes of a row under the current registers, width clamped.
   function automatic int visible_bytes();
      int w;
      w = (cur_width == '0) ? 1 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_width);
      case (cur_fmt)
         FMT_BGRX32: return w * 4;
         FMT_BGR24:  return w * 3;
         default:    return w * 2;
      endcase
   endfunction

   // Padded row length: visible bytes rounded up to a 4-byte multiple.
   function automatic int stride_bytes();
      return (visible_bytes() + 3) & ~3;
   endfunction

   // Takes one byte into the shadow; returns 1 and the pixel when one completes.
   function automatic bit convert_byte(input logic [7:0] b, input logic frame,
                                       output rgb_out_type px);
      int          vis;
      int          pos;
      int          last_idx;
      logic [15:0] word;
      bit          made;
      made     = 1'b0;
      px       = '0;
      vis      = visible_bytes();
      last_idx = (cur_fmt == FMT_BGRX32) ? 3 : (cur_fmt == FMT_BGR24) ? 2 : 1;
      if (frame) begin
         row_pos  = '0;
         pix_byte = '0;
         held     = '0;
      end
      pos = int'(row_pos);
      if (pos < vis) begin
         if (int'(pix_byte) < last_idx) begin
            case (pix_byte)
               2'd0:    held = {8'h00, b};
               2'd1:    held = {b, held[7:0]};
               // 32-bit: red completes the colour, so the packed pixel is kept
               default: held = {b[7:3], held[15:10], held[7:3]};
            endcase
            pix_byte = pix_byte + 2'd1;
         end else begin
            word = {b, held[7:0]};
            case (cur_fmt)
               FMT_RGB555: px.pixel = {word[14:10], word[9:5], 1'b0, word[4:0]};
               FMT_RGB565: px.pixel = word;
               FMT_BGR24:  px.pixel = {b[7:3], held[15:10], held[7:3]};
               default:    px.pixel = held;
            endcase
            px.row_end = (pos + 1 == vis);
            made       = 1'b1;
            pix_byte   = '0;
         end
      end
      pos = pos + 1;
      if (pos >= stride_bytes()) begin
         pos      = 0;
         pix_byte = '0;
      end
      row_pos = POS_BITS'(pos);
      return made;
   endfunction

   // One byte transfer, then perhaps a gap. When typed, the table's pixel is
   // what gets expected, after a check that the shadow agrees with it.
   task automatic send_byte(input logic [7:0] b, input logic frame,
                            input bit typed, input rgb_out_type want);
      rgb_out_type px;
      bit          made;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= frame;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      made = convert_byte(b, frame, px);
      if (typed) begin
         if (!made || px != want) begin
            $error("table row %h/%0b disagrees with prediction %h/%0b (made %0b)",
                   want.pixel, want.row_end, px.pixel, px.row_end, made);
            errors++;
         end
         pending_pixels.push_back(want);
      end else if (made) begin
         pending_pixels.push_back(px);
      end
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Stop sending and let the block empty before the registers are touched.
   // Padding bytes leave nothing in the queue, so a settle wait follows the drain.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [WIDTH_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      if (idx == REG_PIXEL_FORMAT) cur_fmt = fmt_type'(val[1:0]);
      else cur_width = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: every rsp_ transfer is matched against the oldest pixel due.
   always @(posedge clock) begin
      rgb_out_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel transfer %h (row_end %0b) with nothing due", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            due = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_tlast) row_ends_seen++;
            if (rsp_tdata !== due.pixel) begin
               $error("pixel: expected %h, got %h", due.pixel, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== due.row_end) begin
               $error("row_end: expected %0b, got %0b", due.row_end, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request so that
   // the output buffer fills and req_tready has to drop.
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sender and register writes.
   initial begin
      rgb_out_type           want;
      int                    random_bytes;
      int                    phases;
      int                    n_bytes;
      int                    pick;
      logic [WIDTH_BITS-1:0] val;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = REG_PIXEL_FORMAT;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, no idling on either side
      foreach (directed_rows[i]) begin
         want.pixel   = directed_rows[i].pixel;
         want.row_end = directed_rows[i].row_end;
         case (directed_rows[i].kind)
            ROW_FORMAT: begin
               wait_idle();
               write_reg(REG_PIXEL_FORMAT, directed_rows[i].value);
            end
            ROW_WIDTH: begin
               wait_idle();
               write_reg(REG_IMAGE_WIDTH, directed_rows[i].value);
            end
            default: begin
               send_byte(directed_rows[i].value[7:0], directed_rows[i].frame,
                         directed_rows[i].typed, want);
            end
         endcase
      end

      // pressure: long output hold-off while bytes keep coming back to back
      wait_idle();
      write_reg(REG_PIXEL_FORMAT, 12'(FMT_RGB565));
      write_reg(REG_IMAGE_WIDTH, 12'd64);
      hold_output = 1'b1;
      for (int i = 0; i < 160; i++)
         send_byte(8'($urandom), (i == 0), 1'b0, want);

      // random part: well-formed frames with random content, under random
      // settings, with the odd stray frame_start and frames that stop mid-row
      random_bytes = 0;
      phases       = 0;
      while (random_bytes < RANDOM_BYTES) begin
         // the sender pauses here until every pixel due has come back
         wait_idle();
         phases++;
         tx_idle_on = (random_bytes < CALM_BYTES) && ($urandom_range(0, 3) != 0);
         rx_idle_on = (random_bytes < CALM_BYTES) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 6) != 0) begin
            val = WIDTH_BITS'($urandom_range(0, 3));
            // upper bits of a format write are don't-care
            if ($urandom_range(0, 1) != 0) val[WIDTH_BITS-1:2] = 10'($urandom);
            write_reg(REG_PIXEL_FORMAT, val);
         end
         if ($urandom_range(0, 6) != 0) begin
            pick = $urandom_range(0, 19);
            case (pick)
               0:       val = 12'd0;
               1:       val = 12'd2048;
               2:       val = 12'($urandom_range(2049, 4095));
               3, 4:    val = 12'($urandom_range(10, 64));
               default: val = 12'($urandom_range(1, 9));
            endcase
            write_reg(REG_IMAGE_WIDTH, val);
         end
         // a few whole rows plus a ragged tail; wide images get only a slice
         n_bytes = stride_bytes() * $urandom_range(1, 4) + $urandom_range(0, 3);
         if (n_bytes > 200) n_bytes = $urandom_range(40, 200);
         for (int i = 0; i < n_bytes; i++) begin
            // most frames start cleanly; otherwise the counters carry over
            send_byte(8'($urandom),
                      (i == 0) ? ($urandom_range(0, 6) != 0) : ($urandom_range(0, 49) == 0),
                      1'b0, want);
            random_bytes++;
         end
      end

      wait_idle();
      $display("Sent %0d bytes over %0d random settings; checked %0d pixels, %0d row ends.",
               bytes_sent, phases, pixels_checked, row_ends_seen);
      $display("Register writes: %0d, all four formats, widths 0 to 4095 incl. clamping.",
               reg_writes);
      if (errors == 0) begin
         $display("PASS bmp_pixel_to_rgb565");
      end else begin
         $display("FAIL bmp_pixel_to_rgb565");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bp2rgb_pkg.sv
rtl/core/bp2rgb_unpack.sv
rtl/core/bmp_pixel_to_rgb565.sv
tb/bmp_pixel_to_rgb565_test.sv
